// ===== hdl/gha_pkg.sv =====
// Shared codes and controller/datapath interface types for the handle allocator.
package gha_pkg;

  localparam logic [1:0] MODE_CREATE  = 2'd0;
  localparam logic [1:0] MODE_DESTROY = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_DEAD      = 3'd2;
  localparam logic [2:0] ST_MISMATCH  = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic latch;      // capture the accepted item
    logic rd_stack;   // read free stack top
    logic rd_vt;      // read version entry at the input index
    logic rd_vt_pop;  // read version entry at the popped slot
    logic finish;     // update state and load the result register
  } gha_cmd_t;

  typedef struct packed {
    logic stack_nonempty;
    logic idx_known;
    logic out_free;
  } gha_sts_t;

endpackage

// ===== hdl/gha_ctrl.sv =====
// Sequencing state machine for the handle allocator.
module gha_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_mode,
  input  gha_pkg::gha_sts_t sts,
  output gha_pkg::gha_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_POP  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_FIN;
          unique case (in_mode) inside
            gha_pkg::MODE_CREATE: begin
              if (sts.stack_nonempty) begin
                cmd.rd_stack = 1'b1;
                state_nxt    = S_POP;
              end
            end
            gha_pkg::MODE_DESTROY, gha_pkg::MODE_QUERY: begin
              cmd.rd_vt = sts.idx_known;
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        cmd.rd_vt_pop = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the transfer
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hdl/gha_dp.sv =====
// Datapath: version/alive memory, free stack, counters, live range and result register.
module gha_dp #(
  parameter int MAX_ENTITIES = 1024,
  parameter int VERSION_BITS = 16,
  parameter int IDX_W        = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gha_pkg::gha_cmd_t       cmd,
  output gha_pkg::gha_sts_t       sts,
  input  logic [1:0]              in_mode,
  input  logic [IDX_W-1:0]        in_entity_index,
  input  logic [VERSION_BITS-1:0] in_entity_version,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [15:0]             cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [2:0]              out_status,
  output logic [IDX_W-1:0]        out_handle_index,
  output logic [VERSION_BITS-1:0] out_handle_version,
  output logic [15:0]             out_handle_archetype,
  output logic                    out_is_alive,
  output logic                    out_range_valid,
  output logic [IDX_W-1:0]        out_first_live,
  output logic [IDX_W:0]          out_end_live
);

  localparam int CNT_W = IDX_W + 1;
  localparam int VB    = VERSION_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // entry = {alive, version}
  logic [VB:0]      vt_mem [MAX_ENTITIES];
  logic [VB:0]      vt_rd_r;
  logic [IDX_W-1:0] fs_mem [MAX_ENTITIES];
  logic [IDX_W-1:0] fs_rd_r;

  logic [1:0]       mode_r;
  logic [IDX_W-1:0] idx_r;
  logic [VB-1:0]    ver_r;
  logic [15:0]      tag_r;

  logic [CNT_W-1:0] free_r, free_nxt, created_r, created_nxt;
  logic             first_v_r, first_v_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] end_r, end_nxt;

  logic             out_valid_r;
  logic [2:0]       o_status_r;
  logic [IDX_W-1:0] o_idx_r;
  logic [VB-1:0]    o_ver_r;
  logic [15:0]      o_tag_r;
  logic             o_alive_r;
  logic             o_rv_r;
  logic [IDX_W-1:0] o_first_r;
  logic [CNT_W-1:0] o_end_r;

  logic [CNT_W-1:0] free_dec;
  logic [IDX_W-1:0] vt_raddr;

  logic             vt_we, fs_we;
  logic [IDX_W-1:0] vt_waddr;
  logic [VB:0]      vt_wdata;
  logic [2:0]       chk, status_c;
  logic [IDX_W-1:0] idx_c, slot;
  logic [VB-1:0]    ver_c, newver;
  logic             alive_c, made;
  logic [CNT_W-1:0] f_c, e_c;

  assign cfg_ready = 1'b1;
  assign free_dec  = free_r - ONE_CNT;
  assign vt_raddr  = cmd.rd_vt_pop ? fs_rd_r : in_entity_index;

  assign sts.stack_nonempty = (free_r != '0);
  assign sts.idx_known      = ({1'b0, in_entity_index} < created_r);
  assign sts.out_free       = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (vt_we) vt_mem[vt_waddr] <= vt_wdata;
    if (cmd.rd_vt || cmd.rd_vt_pop) vt_rd_r <= vt_mem[vt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[free_r[IDX_W-1:0]] <= idx_r;
    if (cmd.rd_stack) fs_rd_r <= fs_mem[free_dec[IDX_W-1:0]];
  end

  always_comb begin
    if (!({1'b0, idx_r} < created_r))    chk = gha_pkg::ST_NOT_FOUND;
    else if (!vt_rd_r[VB])               chk = gha_pkg::ST_DEAD;
    else if (vt_rd_r[VB-1:0] != ver_r)   chk = gha_pkg::ST_MISMATCH;
    else                                 chk = gha_pkg::ST_OK;
  end

  always_comb begin
    status_c    = gha_pkg::ST_OK;
    idx_c       = idx_r;
    ver_c       = ver_r;
    alive_c     = 1'b0;
    vt_we       = 1'b0;
    vt_waddr    = idx_r;
    vt_wdata    = {1'b0, vt_rd_r[VB-1:0]};
    fs_we       = 1'b0;
    free_nxt    = free_r;
    created_nxt = created_r;
    first_v_nxt = first_v_r;
    first_nxt   = first_r;
    end_nxt     = end_r;
    made        = 1'b0;
    slot        = fs_rd_r;
    newver      = vt_rd_r[VB-1:0] + VB'(1);
    f_c         = {1'b0, first_r};
    e_c         = end_r;
    case (mode_r)
      gha_pkg::MODE_CREATE: begin
        if (free_r != '0) begin
          made     = 1'b1;
          free_nxt = free_dec;
        end else if (created_r < MAX_CNT) begin
          made        = 1'b1;
          slot        = created_r[IDX_W-1:0];
          newver      = VB'(1);
          created_nxt = created_r + ONE_CNT;
        end else begin
          status_c = gha_pkg::ST_FULL;
        end
        if (made) begin
          vt_we    = cmd.finish;
          vt_waddr = slot;
          vt_wdata = {1'b1, newver};
          idx_c    = slot;
          ver_c    = newver;
          if (!first_v_r || slot < first_r) begin
            first_v_nxt = 1'b1;
            first_nxt   = slot;
          end
          if ({1'b0, slot} >= end_r) end_nxt = {1'b0, slot} + ONE_CNT;
        end
      end
      gha_pkg::MODE_DESTROY: begin
        status_c = chk;
        if (chk == gha_pkg::ST_OK) begin
          vt_we = cmd.finish;
          if (free_r < MAX_CNT) begin
            fs_we    = cmd.finish;
            free_nxt = free_r + ONE_CNT;
          end
          if (first_v_r && idx_r == first_r) f_c = {1'b0, first_r} + ONE_CNT;
          if ({1'b0, idx_r} == end_r - ONE_CNT) e_c = end_r - ONE_CNT;
          // collapse the range once first meets end
          if (first_v_r && f_c >= e_c) begin
            first_v_nxt = 1'b0;
            end_nxt     = '0;
          end else begin
            first_nxt = f_c[IDX_W-1:0];
            end_nxt   = e_c;
          end
        end
      end
      gha_pkg::MODE_QUERY: begin
        status_c = chk;
        alive_c  = (chk == gha_pkg::ST_OK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r <= in_mode;
      idx_r  <= in_entity_index;
      ver_r  <= in_entity_version;
    end
    if (cmd.finish) begin
      o_status_r <= status_c;
      o_idx_r    <= idx_c;
      o_ver_r    <= ver_c;
      o_tag_r    <= tag_r;
      o_alive_r  <= alive_c;
      o_rv_r     <= first_v_nxt;
      o_first_r  <= first_v_nxt ? first_nxt : '0;
      o_end_r    <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= '0;
      created_r   <= '0;
      first_v_r   <= 1'b0;
      first_r     <= '0;
      end_r       <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) tag_r <= cfg_data;
      if (cmd.finish) begin
        free_r    <= free_nxt;
        created_r <= created_nxt;
        first_v_r <= first_v_nxt;
        first_r   <= first_nxt;
        end_r     <= end_nxt;
      end
      if (cmd.finish)     out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = o_status_r;
  assign out_handle_index     = o_idx_r;
  assign out_handle_version   = o_ver_r;
  assign out_handle_archetype = o_tag_r;
  assign out_is_alive         = o_alive_r;
  assign out_range_valid      = o_rv_r;
  assign out_first_live       = o_first_r;
  assign out_end_live         = o_end_r;

  a_free_le_created: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= created_r)
    else $error("free count exceeds created count");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    first_v_r |-> ({1'b0, first_r} < end_r))
    else $error("live range first not below end");

  a_finish_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_mem_cmds_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(cmd.rd_vt || cmd.rd_vt_pop || cmd.rd_stack))
    else $error("memory read issued during finish");

endmodule

// ===== hdl/generational_handle_allocator.sv =====
// Top level of the generational handle allocator.
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | mode, entity_index, entity_version
//  out_    | output    | out_valid/stall  | status, handle_*, is_alive, range/live fields
//  cfg_    | input     | cfg_valid/ready  | cfg_data = archetype tag
//
// Destroy, query and fresh create pass through S_IDLE and S_FIN; create from the free stack also passes
// through S_POP, since the stack read must land before the version read of that slot.
// Each memory has one read and one write port; the read-check-write of a version entry sets the pace.
// Synchronous active-low reset clears counters, range, archetype tag and result valid; no clearing pass,
// entries are read only below the created count.
// The next item is taken while a result waits; an item finishes only once the result register frees.
module generational_handle_allocator #(
  parameter int MAX_ENTITIES = 1024,
  parameter int VERSION_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_mode,
  input  logic [$clog2(MAX_ENTITIES)-1:0]      in_entity_index,
  input  logic [VERSION_BITS-1:0]              in_entity_version,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [15:0]                          cfg_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_status,
  output logic [$clog2(MAX_ENTITIES)-1:0]      out_handle_index,
  output logic [VERSION_BITS-1:0]              out_handle_version,
  output logic [15:0]                          out_handle_archetype,
  output logic                                 out_is_alive,
  output logic                                 out_range_valid,
  output logic [$clog2(MAX_ENTITIES)-1:0]      out_first_live,
  output logic [$clog2(MAX_ENTITIES):0]        out_end_live
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);

  gha_pkg::gha_cmd_t cmd;
  gha_pkg::gha_sts_t sts;

  gha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  gha_dp #(
    .MAX_ENTITIES (MAX_ENTITIES),
    .VERSION_BITS (VERSION_BITS),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_mode              (in_mode),
    .in_entity_index      (in_entity_index),
    .in_entity_version    (in_entity_version),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_handle_index     (out_handle_index),
    .out_handle_version   (out_handle_version),
    .out_handle_archetype (out_handle_archetype),
    .out_is_alive         (out_is_alive),
    .out_range_valid      (out_range_valid),
    .out_first_live       (out_first_live),
    .out_end_live         (out_end_live)
  );

endmodule
